// ===== design/dbv_pkg.sv =====
// Shared types, codes and constants of the dB volume unit.
package dbv_pkg;

    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MUL_W      = 33;
    localparam int FRAC_STEPS = 16;
    localparam int RAMP_EXTRA = 7;

    localparam logic [MUL_W-1:0] LOG_COEF = 33'd2786635;
    localparam logic [23:0]      GAIN_MAX = 24'hFFFFFF;

    typedef enum logic [OP_W-1:0] {
        OP_SET    = 3'd0,
        OP_PRESET = 3'd1,
        OP_INC    = 3'd2,
        OP_DEC    = 3'd3,
        OP_GET    = 3'd4,
        OP_SAMPLE = 3'd5
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS  = 3'd0,
        CFG_BLOCK     = 3'd1,
        CFG_FLOOR     = 3'd2,
        CFG_FLOOR_UNB = 3'd3,
        CFG_CEILING   = 3'd4,
        CFG_STEP      = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXP_MUL,
        S_EXP_SPLIT,
        S_FR_MUL,
        S_FR_ACC,
        S_GAIN,
        S_DIV,
        S_SMUL,
        S_SRES,
        S_DONE
    } t_state;

    typedef logic [31:0] t_sqrt_tab [FRAC_STEPS];

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Repeated square roots of two in Q30: 2^(2^-(k+1)).
    function automatic t_sqrt_tab build_sqrt_tab();
        t_sqrt_tab t;
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int k = 0; k < FRAC_STEPS; k++) begin
            c = isqrt64(c << 30);
            t[k] = c[31:0];
        end
        return t;
    endfunction

    localparam t_sqrt_tab SQRT_TAB = build_sqrt_tab();

endpackage

// ===== design/dbv_in_if.sv =====
// Request channel of the dB volume unit.
interface dbv_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic [dbv_pkg::OP_W-1:0]      op;
    logic signed [15:0]            level_db;
    logic                          silence;
    logic                          custom_step;
    logic signed [15:0]            step_value;
    logic [2:0]                    channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (
        output valid, op, level_db, silence, custom_step, step_value, channel, sample_in,
        input  ready
    );
    modport sink (
        input  valid, op, level_db, silence, custom_step, step_value, channel, sample_in,
        output ready
    );
endinterface

// ===== design/dbv_out_if.sv =====
// Result channel of the dB volume unit.
interface dbv_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic                          is_sample;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [2:0]                    channel_out;
    logic signed [15:0]            volume_db;
    logic                          muted;

    modport source (
        output valid, is_sample, sample_out, channel_out, volume_db, muted,
        input  ready
    );
    modport sink (
        input  valid, is_sample, sample_out, channel_out, volume_db, muted,
        output ready
    );
endinterface

// ===== design/db_volume_with_gain_ramp_unit.sv =====
// Volume in 1/256 dB with dB-to-gain conversion and a linear per-block gain ramp.
// Get, mute and unchanged commands go straight to the result; level commands run
// the exponent and 16 square-root products on the one shared multiplier. Samples
// multiply, then round; a multi-frame block's first sample waits on the step divider.
// The next request is taken once the result is registered, even if it still waits.
// Reset (synchronous, i_rst_n low): muted, gains and ramp zero, registers to defaults.
module db_volume_with_gain_ramp_unit #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_BLOCK    = 4096,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dbv_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dbv_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    dbv_in_if.sink                           i_req,
    dbv_out_if.source                        o_rsp
);
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int BLK_W = $clog2(MAX_BLOCK + 1);
    localparam int MW    = dbv_pkg::MUL_W;
    localparam logic signed [38:0] SMP_MAX = 39'((40'd1 << (SAMPLE_BITS - 1)) - 40'd1);
    localparam logic signed [38:0] SMP_MIN = -SMP_MAX - 39'sd1;

    // configuration
    logic [3:0]         r_cfg_chan;
    logic [12:0]        r_cfg_blk;
    logic signed [15:0] r_cfg_floor;
    logic               r_cfg_unb;
    logic signed [15:0] r_cfg_ceil;
    logic signed [15:0] r_cfg_step;

    // volume and ramp state
    dbv_pkg::t_state    r_state, n_state;
    logic               r_mute;
    logic signed [15:0] r_vol;
    logic [23:0]        r_target;
    logic [23:0]        r_present;
    logic [31:0]        r_ramp_gain;
    logic signed [31:0] r_ramp_step;
    logic [23:0]        r_ramp_target;
    logic [BLK_W-1:0]   r_frame;
    logic               r_open;

    // per-request working registers
    logic signed [15:0]            r_level;
    logic                          r_preset;
    logic                          r_is_sample;
    logic                          r_last;
    logic [2:0]                    r_ch;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [SAMPLE_BITS-1:0] r_samp_res;
    logic [15:0]                   r_frac;
    logic signed [9:0]             r_sh;
    logic [31:0]                   r_m;
    logic [3:0]                    r_k;
    logic signed [2*MW-1:0]        r_prod;

    // result register
    logic                          r_out_valid;
    logic                          r_o_is_sample;
    logic signed [SAMPLE_BITS-1:0] r_o_sample;
    logic [2:0]                    r_o_ch;
    logic signed [15:0]            r_o_vol;
    logic                          r_o_muted;

    logic               in_ready;
    logic               accept;
    logic               out_load;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quot;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    dbv_pkg::t_op       req_op;

    logic [CH_W-1:0]    nch;
    logic [BLK_W-1:0]   nb;
    logic               nb_gt1;
    logic               ch_last;
    logic signed [15:0] step_sel;
    logic signed [17:0] sum_inc;
    logic signed [17:0] diff_dec;
    logic signed [17:0] dec_pre;
    logic signed [15:0] lvl_set;
    logic signed [15:0] lvl_inc;
    logic signed [15:0] lvl_dec;
    logic signed [24:0] gain_diff;
    logic signed [31:0] diff_full;
    logic [41:0]        exp_u;
    logic [63:0]        m_round;
    logic [23:0]        gain_val;
    logic [40:0]        sh_right;
    logic [54:0]        sh_left;
    logic [9:0]         sh_neg;
    logic signed [65:0] s_rnd;
    logic signed [38:0] s_q;
    logic [SAMPLE_BITS-1:0] s_sat;
    logic [BLK_W:0]     frame_inc;

    function automatic logic signed [15:0] clamp_level(
        input logic signed [17:0] v,
        input logic               unb,
        input logic signed [15:0] fl,
        input logic signed [15:0] cl
    );
        logic signed [17:0] t;
        t = v;
        if (!unb && t < 18'(fl)) begin
            t = 18'(fl);
        end else if (t > 18'(cl)) begin
            t = 18'(cl);
        end
        if (t < -18'sd32768) begin
            t = -18'sd32768;
        end
        if (t > 18'sd32767) begin
            t = 18'sd32767;
        end
        return t[15:0];
    endfunction

    // request decode and level candidates
    always_comb begin
        req_op = dbv_pkg::t_op'(i_req.op);

        if (r_cfg_chan == 4'd0) begin
            nch = CH_W'(1);
        end else if (32'(r_cfg_chan) > MAX_CHANNELS) begin
            nch = CH_W'(MAX_CHANNELS);
        end else begin
            nch = CH_W'(r_cfg_chan);
        end
        ch_last = (32'(i_req.channel) + 32'd1) == 32'(nch);

        if (r_cfg_blk == 13'd0) begin
            nb = BLK_W'(1);
        end else if (32'(r_cfg_blk) > MAX_BLOCK) begin
            nb = BLK_W'(MAX_BLOCK);
        end else begin
            nb = BLK_W'(r_cfg_blk);
        end
        nb_gt1 = nb > BLK_W'(1);

        step_sel = i_req.custom_step ? i_req.step_value : r_cfg_step;
        sum_inc  = 18'(r_vol) + 18'(step_sel);
        diff_dec = 18'(r_vol) - 18'(step_sel);
        dec_pre  = (!r_cfg_unb && diff_dec < 18'(r_cfg_floor)) ? 18'(r_cfg_floor) : diff_dec;
        lvl_set  = clamp_level(18'(i_req.level_db), r_cfg_unb, r_cfg_floor, r_cfg_ceil);
        lvl_inc  = r_mute ? clamp_level(18'(r_cfg_floor), r_cfg_unb, r_cfg_floor, r_cfg_ceil)
                          : clamp_level(sum_inc, r_cfg_unb, r_cfg_floor, r_cfg_ceil);
        lvl_dec  = clamp_level(dec_pre, r_cfg_unb, r_cfg_floor, r_cfg_ceil);

        gain_diff = $signed({1'b0, r_target}) - $signed({1'b0, r_present});
        diff_full = $signed({{7{gain_diff[24]}}, gain_diff} << dbv_pkg::RAMP_EXTRA);
    end

    // datapath helpers for the exponent, gain shift and sample rounding
    always_comb begin
        exp_u   = 42'(r_prod) + 42'd32768 + (42'd1 << 40);
        m_round = 64'(r_prod) + (64'd1 << 29);
        sh_neg  = 10'(-r_sh);
        sh_right = '0;
        sh_left  = '0;
        if (r_sh >= 10'sd40) begin
            gain_val = '0;
        end else if (r_sh > 10'sd0) begin
            sh_right = ({9'd0, r_m} + (41'd1 << (r_sh[5:0] - 6'd1))) >> r_sh[5:0];
            gain_val = (sh_right > 41'(dbv_pkg::GAIN_MAX)) ? dbv_pkg::GAIN_MAX
                                                            : sh_right[23:0];
        end else if (sh_neg >= 10'd24) begin
            gain_val = dbv_pkg::GAIN_MAX;
        end else begin
            sh_left  = {23'd0, r_m} << sh_neg[4:0];
            gain_val = (sh_left > 55'(dbv_pkg::GAIN_MAX)) ? dbv_pkg::GAIN_MAX
                                                           : sh_left[23:0];
        end

        s_rnd = r_prod + (66'sd1 <<< 26);
        s_q   = 39'(s_rnd >>> 27);
        if (s_q > SMP_MAX) begin
            s_sat = SAMPLE_BITS'(SMP_MAX);
        end else if (s_q < SMP_MIN) begin
            s_sat = SAMPLE_BITS'(SMP_MIN);
        end else begin
            s_sat = s_q[SAMPLE_BITS-1:0];
        end

        frame_inc = {1'b0, r_frame} + (BLK_W + 1)'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dbv_pkg::S_IDLE: begin
                if (accept) begin
                    case (req_op)
                        dbv_pkg::OP_SET, dbv_pkg::OP_PRESET: begin
                            n_state = i_req.silence ? dbv_pkg::S_DONE : dbv_pkg::S_EXP_MUL;
                        end
                        dbv_pkg::OP_INC: begin
                            n_state = (r_mute && r_cfg_unb) ? dbv_pkg::S_DONE
                                                            : dbv_pkg::S_EXP_MUL;
                        end
                        dbv_pkg::OP_DEC: begin
                            n_state = r_mute ? dbv_pkg::S_DONE : dbv_pkg::S_EXP_MUL;
                        end
                        dbv_pkg::OP_SAMPLE: begin
                            n_state = (!r_open && nb_gt1) ? dbv_pkg::S_DIV : dbv_pkg::S_SMUL;
                        end
                        default: begin
                            n_state = dbv_pkg::S_DONE;
                        end
                    endcase
                end
            end
            dbv_pkg::S_EXP_MUL:   n_state = dbv_pkg::S_EXP_SPLIT;
            dbv_pkg::S_EXP_SPLIT: n_state = dbv_pkg::S_FR_MUL;
            dbv_pkg::S_FR_MUL:    n_state = dbv_pkg::S_FR_ACC;
            dbv_pkg::S_FR_ACC: begin
                n_state = (r_k == 4'd15) ? dbv_pkg::S_GAIN : dbv_pkg::S_FR_MUL;
            end
            dbv_pkg::S_GAIN:      n_state = dbv_pkg::S_DONE;
            dbv_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = dbv_pkg::S_SMUL;
                end
            end
            dbv_pkg::S_SMUL:      n_state = dbv_pkg::S_SRES;
            dbv_pkg::S_SRES:      n_state = dbv_pkg::S_DONE;
            dbv_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = dbv_pkg::S_IDLE;
                end
            end
            default:              n_state = dbv_pkg::S_IDLE;
        endcase
    end

    // control outputs and shared multiplier operands
    always_comb begin
        in_ready  = (r_state == dbv_pkg::S_IDLE);
        accept    = i_req.valid && in_ready;
        out_load  = (r_state == dbv_pkg::S_DONE) && (!r_out_valid || o_rsp.ready);
        div_start = accept && (req_op == dbv_pkg::OP_SAMPLE) && !r_open && nb_gt1;
        mul_a     = '0;
        mul_b     = '0;
        case (r_state)
            dbv_pkg::S_EXP_MUL: begin
                mul_a = MW'(r_level);
                mul_b = $signed(dbv_pkg::LOG_COEF);
            end
            dbv_pkg::S_FR_MUL: begin
                mul_a = $signed({1'b0, r_m});
                mul_b = $signed({1'b0, dbv_pkg::SQRT_TAB[r_k]});
            end
            dbv_pkg::S_SMUL: begin
                mul_a = MW'(r_sample);
                mul_b = $signed({1'b0, r_ramp_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dbv_div #(
        .DEN_W (BLK_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (diff_full),
        .i_den   (nb - BLK_W'(1)),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_chan  <= 4'd2;
            r_cfg_blk   <= 13'd256;
            r_cfg_floor <= -16'sd32768;
            r_cfg_unb   <= 1'b1;
            r_cfg_ceil  <= 16'sd2560;
            r_cfg_step  <= 16'sd256;
        end else if (i_cfg_we) begin
            case (dbv_pkg::t_cfg_idx'(i_cfg_idx))
                dbv_pkg::CFG_CHANNELS:  r_cfg_chan  <= i_cfg_data[3:0];
                dbv_pkg::CFG_BLOCK:     r_cfg_blk   <= i_cfg_data[12:0];
                dbv_pkg::CFG_FLOOR:     r_cfg_floor <= $signed(i_cfg_data);
                dbv_pkg::CFG_FLOOR_UNB: r_cfg_unb   <= i_cfg_data[0];
                dbv_pkg::CFG_CEILING:   r_cfg_ceil  <= $signed(i_cfg_data);
                dbv_pkg::CFG_STEP:      r_cfg_step  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // volume, gain and ramp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= dbv_pkg::S_IDLE;
            r_mute        <= 1'b1;
            r_vol         <= '0;
            r_target      <= '0;
            r_present     <= '0;
            r_ramp_gain   <= '0;
            r_ramp_step   <= '0;
            r_ramp_target <= '0;
            r_frame       <= '0;
            r_open        <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                dbv_pkg::S_IDLE: begin
                    if (accept) begin
                        case (req_op)
                            dbv_pkg::OP_SET, dbv_pkg::OP_PRESET: begin
                                if (i_req.silence) begin
                                    r_mute   <= 1'b1;
                                    r_vol    <= -16'sd32768;
                                    r_target <= '0;
                                    if (req_op == dbv_pkg::OP_PRESET) begin
                                        r_present     <= '0;
                                        r_ramp_gain   <= '0;
                                        r_ramp_target <= '0;
                                        r_ramp_step   <= '0;
                                    end
                                end else begin
                                    r_mute <= 1'b0;
                                    r_vol  <= lvl_set;
                                end
                            end
                            dbv_pkg::OP_INC: begin
                                if (!(r_mute && r_cfg_unb)) begin
                                    r_mute <= 1'b0;
                                    r_vol  <= lvl_inc;
                                end
                            end
                            dbv_pkg::OP_DEC: begin
                                if (!r_mute) begin
                                    r_vol <= lvl_dec;
                                end
                            end
                            dbv_pkg::OP_SAMPLE: begin
                                // open a block: latch the target and ramp from present
                                if (!r_open) begin
                                    r_ramp_gain   <= {1'b0, r_present, 7'd0};
                                    r_ramp_target <= r_target;
                                    r_open        <= 1'b1;
                                    if (!nb_gt1) begin
                                        r_ramp_step <= diff_full;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                dbv_pkg::S_GAIN: begin
                    r_target <= gain_val;
                    if (r_preset) begin
                        r_present     <= gain_val;
                        r_ramp_gain   <= {1'b0, gain_val, 7'd0};
                        r_ramp_target <= gain_val;
                        r_ramp_step   <= '0;
                    end
                end
                dbv_pkg::S_DIV: begin
                    if (div_done) begin
                        r_ramp_step <= div_quot;
                    end
                end
                dbv_pkg::S_SRES: begin
                    // last channel of the frame: advance ramp and frame count
                    if (r_last) begin
                        r_ramp_gain <= r_ramp_gain + r_ramp_step;
                        if (frame_inc >= {1'b0, nb}) begin
                            r_frame   <= '0;
                            r_open    <= 1'b0;
                            r_present <= r_ramp_target;
                        end else begin
                            r_frame <= frame_inc[BLK_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // per-request working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_preset    <= (req_op == dbv_pkg::OP_PRESET);
            r_is_sample <= (req_op == dbv_pkg::OP_SAMPLE);
            r_ch        <= i_req.channel;
            r_sample    <= i_req.sample_in;
            r_last      <= ch_last;
            case (req_op)
                dbv_pkg::OP_SET, dbv_pkg::OP_PRESET: r_level <= lvl_set;
                dbv_pkg::OP_INC:                     r_level <= lvl_inc;
                default:                             r_level <= lvl_dec;
            endcase
        end
        case (r_state)
            dbv_pkg::S_EXP_SPLIT: begin
                r_frac <= exp_u[31:16];
                r_sh   <= 10'sd266 - $signed({1'b0, exp_u[40:32]});
                r_m    <= 32'd1 << 30;
                r_k    <= '0;
            end
            dbv_pkg::S_FR_ACC: begin
                if (r_frac[4'd15 - r_k]) begin
                    r_m <= m_round[61:30];
                end
                r_k <= r_k + 4'd1;
            end
            dbv_pkg::S_SRES: begin
                r_samp_res <= $signed(s_sat);
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_is_sample <= r_is_sample;
            r_o_sample    <= r_is_sample ? r_samp_res : '0;
            r_o_ch        <= r_is_sample ? r_ch : 3'd0;
            r_o_vol       <= r_mute ? -16'sd32768 : r_vol;
            r_o_muted     <= r_mute;
        end
    end

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.is_sample   = r_o_is_sample;
    assign o_rsp.sample_out  = r_o_sample;
    assign o_rsp.channel_out = r_o_ch;
    assign o_rsp.volume_db   = r_o_vol;
    assign o_rsp.muted       = r_o_muted;

`ifndef SYNTHESIS
    a_mute_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mute |-> (r_target == 24'd0))
        else $error("muted with nonzero target gain");

    a_frac_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbv_pkg::S_FR_ACC && r_k == 4'd15) |=> (r_state == dbv_pkg::S_GAIN))
        else $error("fraction loop did not finish into gain stage");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == dbv_pkg::S_DIV))
        else $error("divider finished outside the divide wait");

    a_preset_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbv_pkg::S_GAIN && r_preset) |=>
            (r_ramp_step == 32'sd0 && r_present == r_target))
        else $error("preset left a ramp in progress");
`endif
endmodule

// ===== design/dbv_div.sv =====
// Restoring signed-by-unsigned divider, one quotient bit per cycle.
module dbv_div #(
    parameter int DEN_W = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [4:0]       r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [31:0]      r_q;
    logic [DEN_W-1:0] r_den;

    logic [31:0]      num_mag;
    logic [DEN_W:0]   shifted;
    logic             q_bit;
    logic [DEN_W:0]   n_rem;

    always_comb begin
        num_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);
        shifted = {r_rem[DEN_W-1:0], r_q[31]};
        q_bit   = shifted >= {1'b0, r_den};
        n_rem   = q_bit ? shifted - {1'b0, r_den} : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= num_mag;
            r_rem <= '0;
            r_cnt <= 5'd31;
            r_neg <= i_num[31];
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[30:0], q_bit};
            r_rem <= n_rem;
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

// ===== verif/db_volume_with_gain_ramp_unit_test.sv =====
// Self-checking testbench of the dB volume unit with per-block gain ramp.
`timescale 1ns / 1ps

module db_volume_with_gain_ramp_unit_test;

    localparam logic [dbv_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [dbv_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int SMP_MAX      = 8388607;
    localparam int SMP_MIN      = -8388608;
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 60;

    typedef struct {
        logic [dbv_pkg::OP_W-1:0] op;
        logic signed [15:0] level;
        logic               silence;
        logic               custom;
        logic signed [15:0] step;
        logic [2:0]         ch;
        logic signed [23:0] smp;
    } t_vol_req;

    typedef struct {
        logic               is_sample;
        logic signed [23:0] smp;
        logic [2:0]         ch;
        logic signed [15:0] vol;
        logic               muted;
    } t_vol_rsp;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [dbv_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [dbv_pkg::CFG_DATA_W-1:0] i_cfg_data;

    dbv_in_if  #(.SAMPLE_BITS(24)) req ();
    dbv_out_if #(.SAMPLE_BITS(24)) rsp ();

    db_volume_with_gain_ramp_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state and register copies
    int          reg_chans, reg_frames, reg_floor, reg_unb, reg_ceil, reg_step;
    bit          mute_q, blk_open;
    int          vol_q, frame_cnt;
    logic [23:0] tgt_gain, cur_gain, blk_target;
    logic [31:0] ramp_acc, ramp_inc;

    t_vol_rsp    expected_rsps[$];
    int          fail_cnt;
    int          idle_cnt;
    bit          gaps_on;
    bit          hold_long;
    int          next_ch;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x_in);
        logic [63:0] x, r, b;
        x = x_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [23:0] level_to_gain(input int d);
        longint      p;
        logic [63:0] u, m, c;
        int          n, sh;
        logic [15:0] f;
        p = longint'(d) * 64'sd2786635;
        u = p + 64'sd32768 + (64'sd1 << 40);
        n = int'(u[63:32]) - 256;
        f = u[31:16];
        m = 64'd1 << 30;
        c = 64'd1 << 31;
        for (int k = 0; k < 16; k++) begin
            c = int_sqrt(c << 30);
            if (f[15-k]) m = (m * c + (64'd1 << 29)) >> 30;
        end
        sh = 10 - n;
        if (sh >= 40) return 24'd0;
        if (sh > 0) begin
            m = (m + (64'd1 << (sh - 1))) >> sh;
        end else begin
            if (-sh >= 24) return dbv_pkg::GAIN_MAX;
            m = m << (-sh);
        end
        return (m > 64'hFFFFFF) ? dbv_pkg::GAIN_MAX : m[23:0];
    endfunction

    function automatic void set_level(input int v_in);
        int v;
        v = v_in;
        if (reg_unb == 0 && v < reg_floor) v = reg_floor;
        else if (v > reg_ceil) v = reg_ceil;
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        mute_q   = 1'b0;
        vol_q    = v;
        tgt_gain = level_to_gain(v);
    endfunction

    function automatic void set_mute();
        mute_q   = 1'b1;
        vol_q    = -32768;
        tgt_gain = '0;
    endfunction

    function automatic void reset_volume_model();
        reg_chans = 2; reg_frames = 256; reg_floor = -32768;
        reg_unb = 1; reg_ceil = 2560; reg_step = 256;
        mute_q = 1'b1; blk_open = 1'b0; vol_q = 0; frame_cnt = 0;
        tgt_gain = '0; cur_gain = '0; blk_target = '0;
        ramp_acc = '0; ramp_inc = '0;
    endfunction

    function automatic t_vol_rsp predict_volume(input t_vol_req r);
        t_vol_rsp res;
        int       stp, nch, nb, nx;
        longint   diff, pr, q;
        res = '{default: '0};
        stp = r.custom ? int'(r.step) : reg_step;
        case (r.op)
            dbv_pkg::OP_SET, dbv_pkg::OP_PRESET: begin
                if (r.silence) set_mute(); else set_level(int'(r.level));
                if (r.op == dbv_pkg::OP_PRESET) begin
                    cur_gain   = tgt_gain;
                    ramp_acc   = {8'd0, tgt_gain} << dbv_pkg::RAMP_EXTRA;
                    blk_target = tgt_gain;
                    ramp_inc   = '0;
                end
            end
            dbv_pkg::OP_INC: begin
                if (mute_q) begin
                    if (reg_unb == 0) set_level(reg_floor);
                end else begin
                    set_level(vol_q + stp);
                end
            end
            dbv_pkg::OP_DEC: begin
                if (!mute_q) begin
                    nx = vol_q - stp;
                    if (reg_unb == 0 && nx < reg_floor) nx = reg_floor;
                    set_level(nx);
                end
            end
            dbv_pkg::OP_SAMPLE: begin
                nch = (reg_chans < 1) ? 1 : (reg_chans > 8) ? 8 : reg_chans;
                nb  = (reg_frames < 1) ? 1 : (reg_frames > 4096) ? 4096 : reg_frames;
                if (!blk_open) begin
                    diff       = (longint'(tgt_gain) - longint'(cur_gain)) * 128;
                    ramp_acc   = {8'd0, cur_gain} << dbv_pkg::RAMP_EXTRA;
                    blk_target = tgt_gain;
                    ramp_inc   = 32'((nb > 1) ? diff / longint'(nb - 1) : diff);
                    blk_open   = 1'b1;
                end
                pr = longint'(r.smp) * longint'(ramp_acc);
                q  = (pr + (64'sd1 << 26)) >>> 27;
                if (q > SMP_MAX) q = SMP_MAX;
                if (q < SMP_MIN) q = SMP_MIN;
                res.is_sample = 1'b1;
                res.smp       = q[23:0];
                res.ch        = r.ch;
                if (int'(r.ch) == nch - 1) begin
                    ramp_acc  = ramp_acc + ramp_inc;
                    frame_cnt = frame_cnt + 1;
                    if (frame_cnt >= nb) begin
                        frame_cnt = 0;
                        blk_open  = 1'b0;
                        cur_gain  = blk_target;
                    end
                end
            end
            default: ;
        endcase
        res.vol   = mute_q ? -16'sd32768 : 16'(vol_q);
        res.muted = mute_q;
        return res;
    endfunction

    task automatic send_request(input t_vol_req r);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid       <= 1'b1;
        req.op          <= r.op;
        req.level_db    <= r.level;
        req.silence     <= r.silence;
        req.custom_step <= r.custom;
        req.step_value  <= r.step;
        req.channel     <= r.ch;
        req.sample_in   <= r.smp;
        do @(posedge i_clk); while (!req.ready);
        expected_rsps.push_back(predict_volume(r));
    endtask

    task automatic release_bus();
        req.valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input dbv_pkg::t_cfg_idx idx, input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            dbv_pkg::CFG_CHANNELS:  reg_chans  = int'(v[3:0]);
            dbv_pkg::CFG_BLOCK:     reg_frames = int'(v[12:0]);
            dbv_pkg::CFG_FLOOR:     reg_floor  = int'($signed(v));
            dbv_pkg::CFG_FLOOR_UNB: reg_unb    = int'(v[0]);
            dbv_pkg::CFG_CEILING:   reg_ceil   = int'($signed(v));
            dbv_pkg::CFG_STEP:      reg_step   = int'($signed(v));
            default: ;
        endcase
    endtask

    function automatic t_vol_req make_cmd(input logic [dbv_pkg::OP_W-1:0] op, input int level,
                                          input bit sil, input bit cust, input int stp);
        t_vol_req r;
        r = '{default: '0};
        r.op = op; r.level = 16'(level); r.silence = sil;
        r.custom = cust; r.step = 16'(stp);
        r.ch = 3'($urandom_range(0, 7)); r.smp = 24'($urandom);
        return r;
    endfunction

    function automatic t_vol_req make_sample(input int ch, input int smp);
        t_vol_req r;
        r = make_cmd(dbv_pkg::OP_SAMPLE, $urandom, $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom);
        r.ch  = 3'(ch);
        r.smp = 24'(smp);
        return r;
    endfunction

    function automatic t_vol_req rand_request();
        t_vol_req r;
        int       sel, nch, lvl, smp;
        sel = $urandom_range(0, 99);
        nch = (reg_chans < 1) ? 1 : (reg_chans > 8) ? 8 : reg_chans;
        if (sel < 70) begin
            // mostly in-order frames, now and then a stray channel
            if ($urandom_range(0, 19) == 0) begin
                next_ch = $urandom_range(0, 7);
            end
            smp = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? SMP_MAX : SMP_MIN)
                                             : int'($signed(24'($urandom)));
            r = make_sample(next_ch, smp);
            next_ch = (next_ch + 1 >= nch) ? 0 : next_ch + 1;
        end else begin
            lvl = ($urandom_range(0, 3) == 0) ? int'($signed(16'($urandom)))
                                             : $urandom_range(0, 30000) - 24000;
            r = make_cmd(3'($urandom_range(0, 7)), lvl, ($urandom_range(0, 7) == 0),
                         $urandom_range(0, 1),
                         ($urandom_range(0, 3) == 0) ? int'($signed(16'($urandom)))
                                                    : $urandom_range(0, 2048) - 1024);
        end
        return r;
    endfunction

    // Result side: random stall per result, with one long hold on request
    initial begin
        int n;
        rsp.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            n = gaps_on ? $urandom_range(0, 15) : 0;
            if (hold_long) begin
                hold_long = 1'b0;
                n = LONG_HOLD;
            end
            if (n > 0) begin
                rsp.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp.valid);
        end
    end

    always @(posedge i_clk) begin
        t_vol_rsp e;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected result is_sample=%0b sample=%0d vol=%0d",
                         $realtime, rsp.is_sample, rsp.sample_out, rsp.volume_db);
                fail_cnt++;
            end else begin
                e = expected_rsps.pop_front();
                if (rsp.is_sample !== e.is_sample || rsp.sample_out !== e.smp ||
                    rsp.channel_out !== e.ch || rsp.volume_db !== e.vol ||
                    rsp.muted !== e.muted) begin
                    $display("%0t: mismatch exp is_sample=%0b sample=%0d ch=%0d vol=%0d muted=%0b",
                             $realtime, e.is_sample, e.smp, e.ch, e.vol, e.muted);
                    $display("%0t:          got is_sample=%0b sample=%0d ch=%0d vol=%0d muted=%0b",
                             $realtime, rsp.is_sample, rsp.sample_out, rsp.channel_out,
                             rsp.volume_db, rsp.muted);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= STALL_LIMIT) begin
            $display("** db_volume_with_gain_ramp_unit: FAILED **");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    task automatic test_reset_state();
        send_request(make_cmd(dbv_pkg::OP_GET, 0, 0, 0, 0));
        send_request(make_sample(0, SMP_MAX));
        send_request(make_sample(1, SMP_MIN));
        send_request(make_cmd(dbv_pkg::OP_INC, 0, 0, 0, 0));   // unbounded floor: stays muted
        send_request(make_cmd(dbv_pkg::OP_DEC, 0, 0, 0, 0));
        release_bus();
    endtask

    task automatic test_directed_commands();
        write_reg(dbv_pkg::CFG_BLOCK, 16'd2);
        send_request(make_cmd(dbv_pkg::OP_PRESET, 32767, 0, 0, 0));
        send_request(make_sample(0, SMP_MAX));
        send_request(make_sample(1, SMP_MIN));
        send_request(make_cmd(dbv_pkg::OP_SET, -32768, 0, 0, 0));
        send_request(make_cmd(dbv_pkg::OP_SET, 0, 1, 0, 0));
        send_request(make_cmd(dbv_pkg::OP_PRESET, -1536, 0, 0, 0));
        send_request(make_cmd(dbv_pkg::OP_INC, 0, 0, 1, 32767));
        send_request(make_cmd(dbv_pkg::OP_DEC, 0, 0, 1, -32768));
        send_request(make_cmd(dbv_pkg::OP_DEC, 0, 0, 1, 32767));
        send_request(make_cmd(dbv_pkg::OP_INC, 0, 0, 0, 0));
        send_request(make_cmd(OP_SPARE_LO, 0, 0, 0, 0));
        send_request(make_cmd(OP_SPARE_HI, 0, 0, 0, 0));
        send_request(make_sample(7, SMP_MAX));        // stray channel keeps the frame
        send_request(make_sample(0, -1));
        send_request(make_sample(1, 1));
        send_request(make_cmd(dbv_pkg::OP_SET, 1024, 0, 0, 0));
        send_request(make_sample(0, 4000000));
        send_request(make_sample(1, -4000000));
        send_request(make_sample(0, SMP_MIN));
        send_request(make_sample(1, SMP_MAX));
        release_bus();
        write_reg(dbv_pkg::CFG_FLOOR, 16'(-2560));
        write_reg(dbv_pkg::CFG_FLOOR_UNB, 16'd0);
        send_request(make_cmd(dbv_pkg::OP_SET, 0, 1, 0, 0));
        send_request(make_cmd(dbv_pkg::OP_INC, 0, 0, 0, 0));   // bounded floor: lands on the floor
        send_request(make_cmd(dbv_pkg::OP_DEC, 0, 0, 1, 20000));
        release_bus();
    endtask

    task automatic test_random_phase(input int chans, input int frames, input int flo,
                                     input int unb, input int ceil_v, input int stp,
                                     input int count, input bit press);
        write_reg(dbv_pkg::CFG_CHANNELS, 16'(chans));
        write_reg(dbv_pkg::CFG_BLOCK, 16'(frames));
        write_reg(dbv_pkg::CFG_FLOOR, 16'(flo));
        write_reg(dbv_pkg::CFG_FLOOR_UNB, 16'(unb));
        write_reg(dbv_pkg::CFG_CEILING, 16'(ceil_v));
        write_reg(dbv_pkg::CFG_STEP, 16'(stp));
        next_ch = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if (press && i == count / 2) begin
                gaps_on   = 1'b0;
                hold_long = 1'b1;
            end
            send_request(rand_request());
        end
        release_bus();
        gaps_on = 1'b1;
    endtask

    initial begin
        reset_volume_model();
        fail_cnt   = 0;
        gaps_on    = 1'b1;
        hold_long  = 1'b0;
        next_ch    = 0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= dbv_pkg::CFG_CHANNELS;
        i_cfg_data <= '0;
        req.valid       <= 1'b0;
        req.op          <= dbv_pkg::OP_GET;
        req.level_db    <= '0;
        req.silence     <= 1'b0;
        req.custom_step <= 1'b0;
        req.step_value  <= '0;
        req.channel     <= '0;
        req.sample_in   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_commands();
        test_random_phase(2, 4, -32768, 1, 2560, 256, 280, 1'b1);
        test_random_phase(1, 1, -6000, 0, 6144, -32768, 280, 1'b0);
        test_random_phase(8, 3, 6144, 0, -32768, 32767, 280, 1'b0);
        test_random_phase(0, 0, -32768, 0, 0, 1, 280, 1'b0);
        test_random_phase(15, 8191, -100, 1, 6144, 512, 280, 1'b0);
        test_random_phase(3, 16, -12000, 0, 1536, 384, 280, 1'b1);

        if (fail_cnt == 0 && expected_rsps.size() == 0) begin
            $display("** db_volume_with_gain_ramp_unit: PASSED **");
        end else begin
            $display("** db_volume_with_gain_ramp_unit: FAILED **");
        end
        $finish;
    end

endmodule
